>>> rtl/assert_macros.svh
// Assertion helpers for the RTL files.
// Every check is sampled on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FPD_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fpd_pkg.sv
`default_nettype none

package fpd_pkg;

  // Field widths of the sensor words.
  localparam int ACCEL_W = 16;
  localparam int ALT_W   = 24;
  localparam int Q_DATA_W = 24;

  // Default window lengths.
  localparam int ACCEL_WINDOW_DEF = 64;
  localparam int ALT_WINDOW_DEF   = 16;

  // Landing is suppressed while the average acceleration is exactly 25 m/s^2 (Q8.8).
  localparam int LAND_ACCEL_EXCL = 25 * 256;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 4;

  // Register reset values.
  localparam logic signed [15:0] LAUNCH_THR_RST = 16'sd5120;
  localparam logic signed [23:0] ALT_THR_RST    = 24'sd80;
  localparam logic [7:0]         MIN_ACC_RST    = 8'd32;

  // Request codes.
  typedef enum logic [1:0] {
    OP_ACCEL = 2'd0,
    OP_ALT   = 2'd1,
    OP_EVAL  = 2'd2,
    OP_FORCE = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LAUNCH_THR = 2'd0,
    CFG_ALT_THR    = 2'd1,
    CFG_MIN_ACC    = 2'd2
  } cfg_idx_t;

  // Flight phases.
  typedef enum logic [1:0] {
    PH_GROUND   = 2'd0,
    PH_LAUNCHED = 2'd1,
    PH_APOGEE   = 2'd2,
    PH_LANDED   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] vertical_accel;
    logic signed [23:0] altitude_sample;
    logic [1:0]         forced_phase;
  } in_word_t;

  typedef struct packed {
    logic       event_detected;
    logic [1:0] flight_phase;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] launch_accel_threshold;
    logic signed [23:0] landing_altitude_threshold;
    logic [7:0]         min_accel_samples;
  } cfg_t;

  // Classified request as it sits in the queue: the kind and its one operand.
  typedef struct packed {
    op_t                 kind;
    logic [Q_DATA_W-1:0] data;
  } q_word_t;

endpackage

`default_nettype wire

>>> rtl/fpd_front.sv
`default_nettype none

module fpd_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire fpd_pkg::in_word_t in_word,
  output logic                   q_valid,
  output fpd_pkg::q_word_t       q_word,
  input  wire logic              q_pop
);

  localparam int PTR_W = $clog2(fpd_pkg::Q_DEPTH);
  localparam int CNT_W = $clog2(fpd_pkg::Q_DEPTH + 1);

  fpd_pkg::q_word_t q_mem_r [fpd_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  fpd_pkg::q_word_t cls_word;

  // The queue is full when every slot holds a word.
  assign in_stall = (count_r == CNT_W'(fpd_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != '0);
  assign q_word   = q_mem_r[rd_ptr_r];

  // Classify the request and keep only the operand that it uses.
  always_comb begin
    cls_word.kind = fpd_pkg::op_t'(in_word.op);
    case (fpd_pkg::op_t'(in_word.op))
      fpd_pkg::OP_ACCEL: cls_word.data = fpd_pkg::Q_DATA_W'(in_word.vertical_accel);
      fpd_pkg::OP_ALT:   cls_word.data = fpd_pkg::Q_DATA_W'(in_word.altitude_sample);
      fpd_pkg::OP_FORCE: cls_word.data = fpd_pkg::Q_DATA_W'(in_word.forced_phase);
      default:           cls_word.data = '0;
    endcase
  end

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(fpd_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(fpd_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_word;
    end
  end

endmodule

`default_nettype wire

>>> rtl/fpd_ring.sv
`default_nettype none

module fpd_ring #(
  parameter int DEPTH = fpd_pkg::ACCEL_WINDOW_DEF,
  parameter int WIDTH = fpd_pkg::ACCEL_W
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_vld_r;

  // Sample storage; entries are never cleared, their valid bits are.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // An entry not written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> rtl/fpd_back.sv
`default_nettype none

module fpd_back #(
  parameter int ACCEL_WINDOW = fpd_pkg::ACCEL_WINDOW_DEF,
  parameter int ALT_WINDOW   = fpd_pkg::ALT_WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fpd_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire fpd_pkg::q_word_t   q_word,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fpd_pkg::out_word_t      out_word
);

  localparam int ACC_PTR_W = $clog2(ACCEL_WINDOW);
  localparam int ALT_PTR_W = $clog2(ALT_WINDOW);
  localparam int ACC_SUM_W = fpd_pkg::ACCEL_W + ACC_PTR_W;
  localparam int ALT_SUM_W = fpd_pkg::ALT_W + ALT_PTR_W;
  localparam logic signed [ACC_SUM_W-1:0] ACC_WIN_S = ACC_SUM_W'(ACCEL_WINDOW);
  localparam logic signed [ALT_SUM_W-1:0] ALT_WIN_S = ALT_SUM_W'(ALT_WINDOW);
  localparam logic signed [ACC_SUM_W-1:0] ACC_EXCL =
    ACC_SUM_W'(fpd_pkg::LAND_ACCEL_EXCL * ACCEL_WINDOW);

  // Issue stage: the word whose old ring entry is being read.
  logic                   s1_valid_r, s1_valid_nxt;
  fpd_pkg::q_word_t       s1_word_r;
  logic [ACC_PTR_W-1:0]   s1_acc_addr_r;
  logic [ALT_PTR_W-1:0]   s1_alt_addr_r;
  logic                   s1_is_eval;
  logic                   s1_adv;

  // Architectural state.
  logic [ACC_PTR_W-1:0]         acc_ptr_r, acc_ptr_nxt;
  logic [ALT_PTR_W-1:0]         alt_ptr_r, alt_ptr_nxt;
  logic signed [ACC_SUM_W-1:0]  acc_sum_r, acc_sum_nxt;
  logic signed [ALT_SUM_W-1:0]  alt_sum_r, alt_sum_nxt;
  logic [7:0]                   acc_count_r, acc_count_nxt;
  fpd_pkg::phase_t              phase_r, phase_nxt;
  logic                         armed_r, armed_nxt;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  fpd_pkg::out_word_t   out_word_r, out_word_nxt;
  logic                 out_load;

  // Ring ports.
  logic                          acc_rd_en, alt_rd_en;
  logic                          acc_wr_en, alt_wr_en;
  logic [fpd_pkg::ACCEL_W-1:0]   acc_old;
  logic [fpd_pkg::ALT_W-1:0]     alt_old;

  // Evaluate terms.
  logic signed [ACC_SUM_W-1:0] acc_lim;
  logic signed [ALT_SUM_W-1:0] alt_lim;
  logic                        acc_hi, alt_hi, alt_lo, acc_ne;
  logic                        evt;
  fpd_pkg::phase_t             ph_a, ph_b, ph_c;
  logic                        arm_a, arm_b, arm_c;

  // An evaluate waits only for room in the result register.
  assign s1_is_eval = (s1_word_r.kind == fpd_pkg::OP_EVAL);
  assign s1_adv     = s1_valid_r && (!s1_is_eval || !out_valid_r || !out_stall);
  assign q_pop      = q_valid && (!s1_valid_r || s1_adv);

  assign acc_rd_en = q_pop && (q_word.kind == fpd_pkg::OP_ACCEL);
  assign alt_rd_en = q_pop && (q_word.kind == fpd_pkg::OP_ALT);
  assign acc_wr_en = s1_adv && (s1_word_r.kind == fpd_pkg::OP_ACCEL);
  assign alt_wr_en = s1_adv && (s1_word_r.kind == fpd_pkg::OP_ALT);

  fpd_ring #(
    .DEPTH (ACCEL_WINDOW),
    .WIDTH (fpd_pkg::ACCEL_W)
  ) u_acc_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (acc_rd_en),
    .rd_addr (acc_ptr_r),
    .wr_en   (acc_wr_en),
    .wr_addr (s1_acc_addr_r),
    .wr_data (s1_word_r.data[fpd_pkg::ACCEL_W-1:0]),
    .rd_data (acc_old)
  );

  fpd_ring #(
    .DEPTH (ALT_WINDOW),
    .WIDTH (fpd_pkg::ALT_W)
  ) u_alt_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (alt_rd_en),
    .rd_addr (alt_ptr_r),
    .wr_en   (alt_wr_en),
    .wr_addr (s1_alt_addr_r),
    .wr_data (s1_word_r.data[fpd_pkg::ALT_W-1:0]),
    .rd_data (alt_old)
  );

  // Ring pointers advance when a sample is issued.
  always_comb begin
    acc_ptr_nxt = acc_ptr_r;
    alt_ptr_nxt = alt_ptr_r;
    if (acc_rd_en) begin
      acc_ptr_nxt = (acc_ptr_r == ACC_PTR_W'(ACCEL_WINDOW - 1)) ? '0 : acc_ptr_r + 1'b1;
    end
    if (alt_rd_en) begin
      alt_ptr_nxt = (alt_ptr_r == ALT_PTR_W'(ALT_WINDOW - 1)) ? '0 : alt_ptr_r + 1'b1;
    end
  end

  assign s1_valid_nxt = q_pop || (s1_valid_r && !s1_adv);

  // Average tests compare the window sum with threshold times window.
  assign acc_lim = ACC_SUM_W'($signed(cfg.launch_accel_threshold)) * ACC_WIN_S;
  assign alt_lim = ALT_SUM_W'($signed(cfg.landing_altitude_threshold)) * ALT_WIN_S;
  assign acc_hi  = (acc_sum_r > acc_lim);
  assign alt_hi  = (alt_sum_r > alt_lim);
  assign alt_lo  = (alt_sum_r < alt_lim);
  assign acc_ne  = (acc_sum_r != ACC_EXCL);

  // Launch, landing and apogee checks, each seeing the phase the one before left.
  always_comb begin
    ph_a  = phase_r;
    arm_a = armed_r;
    ph_b  = phase_r;
    arm_b = armed_r;
    ph_c  = phase_r;
    arm_c = armed_r;
    evt   = 1'b0;
    if ((phase_r == fpd_pkg::PH_GROUND && acc_hi &&
         acc_count_r >= cfg.min_accel_samples && alt_hi) ||
        (phase_r == fpd_pkg::PH_LAUNCHED && armed_r)) begin
      ph_a  = fpd_pkg::PH_LAUNCHED;
      arm_a = 1'b0;
      evt   = 1'b1;
    end
    ph_b  = ph_a;
    arm_b = arm_a;
    if (((ph_a == fpd_pkg::PH_LAUNCHED || ph_a == fpd_pkg::PH_APOGEE) && alt_lo && acc_ne) ||
        (ph_a == fpd_pkg::PH_LANDED && arm_a)) begin
      ph_b  = fpd_pkg::PH_LANDED;
      arm_b = 1'b0;
      evt   = 1'b1;
    end
    ph_c  = ph_b;
    arm_c = arm_b;
    if ((ph_b == fpd_pkg::PH_LAUNCHED && acc_hi) ||
        (ph_b == fpd_pkg::PH_APOGEE && arm_b)) begin
      ph_c  = fpd_pkg::PH_APOGEE;
      arm_c = 1'b0;
      evt   = 1'b1;
    end
  end

  // Execute the word leaving the issue stage.
  always_comb begin
    acc_sum_nxt   = acc_sum_r;
    alt_sum_nxt   = alt_sum_r;
    acc_count_nxt = acc_count_r;
    phase_nxt     = phase_r;
    armed_nxt     = armed_r;
    out_load      = 1'b0;
    out_word_nxt  = out_word_r;
    if (s1_adv) begin
      case (s1_word_r.kind)
        fpd_pkg::OP_ACCEL: begin
          acc_sum_nxt = acc_sum_r
                      + ACC_SUM_W'($signed(s1_word_r.data[fpd_pkg::ACCEL_W-1:0]))
                      - ACC_SUM_W'($signed(acc_old));
          if (acc_count_r != 8'hFF) begin
            acc_count_nxt = acc_count_r + 1'b1;
          end
        end
        fpd_pkg::OP_ALT: begin
          alt_sum_nxt = alt_sum_r
                      + ALT_SUM_W'($signed(s1_word_r.data[fpd_pkg::ALT_W-1:0]))
                      - ALT_SUM_W'($signed(alt_old));
        end
        fpd_pkg::OP_FORCE: begin
          phase_nxt = fpd_pkg::phase_t'(s1_word_r.data[1:0]);
          armed_nxt = 1'b1;
        end
        fpd_pkg::OP_EVAL: begin
          phase_nxt                 = ph_c;
          armed_nxt                 = arm_c;
          out_load                  = 1'b1;
          out_word_nxt.event_detected = evt;
          out_word_nxt.flight_phase   = ph_c;
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      acc_ptr_r   <= '0;
      alt_ptr_r   <= '0;
      acc_sum_r   <= '0;
      alt_sum_r   <= '0;
      acc_count_r <= '0;
      phase_r     <= fpd_pkg::PH_GROUND;
      armed_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      acc_ptr_r   <= acc_ptr_nxt;
      alt_ptr_r   <= alt_ptr_nxt;
      acc_sum_r   <= acc_sum_nxt;
      alt_sum_r   <= alt_sum_nxt;
      acc_count_r <= acc_count_nxt;
      phase_r     <= phase_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_word_r     <= q_word;
      s1_acc_addr_r <= acc_ptr_r;
      s1_alt_addr_r <= alt_ptr_r;
    end
    if (out_load) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

>>> rtl/flight_phase_detector.sv
// An evaluate word passes through the queue, the issue stage and the result register.
// One word per cycle unless stalled; window sums take one add and one subtract a cycle.
// The result register stalls evaluates only; a four-word queue absorbs short output stalls.
// Reset (rst_n low, synchronous) empties the queue, zeroes the sums and rings,
// sets the phase to ground and loads the register defaults; no clearing pass follows.
`default_nettype none
`include "assert_macros.svh"

module flight_phase_detector #(
  parameter int ACCEL_WINDOW = fpd_pkg::ACCEL_WINDOW_DEF,
  parameter int ALT_WINDOW   = fpd_pkg::ALT_WINDOW_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire fpd_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output fpd_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_data
);

  fpd_pkg::cfg_t    cfg_r, cfg_nxt;
  logic             q_valid;
  fpd_pkg::q_word_t q_word;
  logic             q_pop;

  // Register writes are always taken; an index beyond the list is dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (fpd_pkg::cfg_idx_t'(cfg_index))
        fpd_pkg::CFG_LAUNCH_THR: cfg_nxt.launch_accel_threshold     = cfg_data[15:0];
        fpd_pkg::CFG_ALT_THR:    cfg_nxt.landing_altitude_threshold = cfg_data;
        fpd_pkg::CFG_MIN_ACC:    cfg_nxt.min_accel_samples          = cfg_data[7:0];
        default:                 cfg_nxt                            = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.launch_accel_threshold     <= fpd_pkg::LAUNCH_THR_RST;
      cfg_r.landing_altitude_threshold <= fpd_pkg::ALT_THR_RST;
      cfg_r.min_accel_samples          <= fpd_pkg::MIN_ACC_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fpd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  fpd_back #(
    .ACCEL_WINDOW (ACCEL_WINDOW),
    .ALT_WINDOW   (ALT_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_word    (q_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // The back never takes a word from an empty queue.
  `FPD_ASSERT_SAME(a_pop_nonempty, q_pop, q_valid, "word popped from an empty queue")
  // A full queue always offers a word to the back.
  `FPD_ASSERT_SAME(a_full_offers, in_stall, q_valid, "queue stalls input while empty")
  // Out of reset there is no result pending and the queue takes words.
  `FPD_ASSERT_SAME(a_reset_clean, $past(!rst_n), !out_valid && !in_stall,
    "state not clean after reset")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
module tb_top;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int BLOCK_WORDS    = 200;
  localparam int N_BLOCKS       = 5;
  localparam int N_DIRECTED     = 21;
  // Index 3 has no register behind it; a write there must change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One row of the directed list; want_* is used only where typed is set.
  typedef struct packed {
    fpd_pkg::op_t       op;
    logic signed [15:0] accel;
    logic signed [23:0] alt;
    fpd_pkg::phase_t    force_to;
    logic               typed;
    logic               want_event;
    fpd_pkg::phase_t    want_phase;
  } step_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  fpd_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  fpd_pkg::out_word_t out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;

  flight_phase_detector dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the detector state and its registers.
  logic signed [15:0] acc_ring [fpd_pkg::ACCEL_WINDOW_DEF];
  logic signed [22:0] acc_total;
  logic [5:0]         acc_pos;
  logic [7:0]         acc_seen;
  logic signed [23:0] alt_ring [fpd_pkg::ALT_WINDOW_DEF];
  logic signed [27:0] alt_total;
  logic [3:0]         alt_pos;
  fpd_pkg::phase_t    cur_phase;
  logic               armed;
  logic signed [15:0] thr_accel;
  logic signed [23:0] thr_alt;
  logic [7:0]         min_seen;

  fpd_pkg::out_word_t phase_reports_due[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;
  int mismatches = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  step_row_t directed_rows [N_DIRECTED] = '{
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b1, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ACCEL, 16'sh7fff, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ACCEL, 16'sh8000, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ALT, 16'sd0, 24'sh7fffff, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ALT, 16'sd0, 24'sh800000, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_FORCE, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ACCEL, 16'sd6400, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_FORCE, 16'sd0, 24'sd0, fpd_pkg::PH_APOGEE, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_FORCE, 16'sd0, 24'sd0, fpd_pkg::PH_LANDED, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b1, 1'b1, fpd_pkg::PH_LANDED},
    '{fpd_pkg::OP_FORCE, 16'sd0, 24'sd0, fpd_pkg::PH_LAUNCHED, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ALT, 16'sd0, 24'sd1, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ACCEL, -16'sd1, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_FORCE, 16'sd0, 24'sd0, fpd_pkg::PH_LAUNCHED, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_ACCEL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND},
    '{fpd_pkg::OP_EVAL, 16'sd0, 24'sd0, fpd_pkg::PH_GROUND, 1'b0, 1'b0, fpd_pkg::PH_GROUND}
  };

  // Bring the shadow state to its post-reset values.
  task automatic clear_detector_model();
    foreach (acc_ring[i]) acc_ring[i] = '0;
    foreach (alt_ring[i]) alt_ring[i] = '0;
    acc_total = '0;
    acc_pos   = '0;
    acc_seen  = '0;
    alt_total = '0;
    alt_pos   = '0;
    cur_phase = fpd_pkg::PH_GROUND;
    armed     = 1'b0;
    thr_accel = fpd_pkg::LAUNCH_THR_RST;
    thr_alt   = fpd_pkg::ALT_THR_RST;
    min_seen  = fpd_pkg::MIN_ACC_RST;
  endtask

  // Apply one accepted word to the shadow state; an evaluate yields a phase report.
  task automatic track_flight(input fpd_pkg::in_word_t w, output logic gives,
                              output fpd_pkg::out_word_t res);
    int acc_now, acc_lim, alt_now, alt_lim;
    logic acc_hi, alt_hi, alt_lo, acc_ne, fired;
    gives = 1'b0;
    res = '0;
    case (fpd_pkg::op_t'(w.op))
      fpd_pkg::OP_ACCEL: begin
        acc_total = acc_total + w.vertical_accel - acc_ring[acc_pos];
        acc_ring[acc_pos] = w.vertical_accel;
        acc_pos = acc_pos + 6'd1;
        if (acc_seen != 8'd255) acc_seen = acc_seen + 8'd1;
      end
      fpd_pkg::OP_ALT: begin
        alt_total = alt_total + w.altitude_sample - alt_ring[alt_pos];
        alt_ring[alt_pos] = w.altitude_sample;
        alt_pos = alt_pos + 4'd1;
      end
      fpd_pkg::OP_FORCE: begin
        cur_phase = fpd_pkg::phase_t'(w.forced_phase);
        armed = 1'b1;
      end
      fpd_pkg::OP_EVAL: begin
        // Averages are compared as sums against threshold times window length.
        acc_now = int'(acc_total);
        acc_lim = int'(thr_accel) * fpd_pkg::ACCEL_WINDOW_DEF;
        alt_now = int'(alt_total);
        alt_lim = int'(thr_alt) * fpd_pkg::ALT_WINDOW_DEF;
        acc_hi = acc_now > acc_lim;
        alt_hi = alt_now > alt_lim;
        alt_lo = alt_now < alt_lim;
        acc_ne = acc_now != fpd_pkg::LAND_ACCEL_EXCL * fpd_pkg::ACCEL_WINDOW_DEF;
        fired = 1'b0;
        // Launch, landing, apogee, each seeing the phase the previous one left.
        if ((cur_phase == fpd_pkg::PH_GROUND && acc_hi && acc_seen >= min_seen && alt_hi) ||
            (cur_phase == fpd_pkg::PH_LAUNCHED && armed)) begin
          cur_phase = fpd_pkg::PH_LAUNCHED;
          fired = 1'b1;
          armed = 1'b0;
        end
        if (((cur_phase == fpd_pkg::PH_LAUNCHED || cur_phase == fpd_pkg::PH_APOGEE) &&
             alt_lo && acc_ne) ||
            (cur_phase == fpd_pkg::PH_LANDED && armed)) begin
          cur_phase = fpd_pkg::PH_LANDED;
          fired = 1'b1;
          armed = 1'b0;
        end
        if ((cur_phase == fpd_pkg::PH_LAUNCHED && acc_hi) ||
            (cur_phase == fpd_pkg::PH_APOGEE && armed)) begin
          cur_phase = fpd_pkg::PH_APOGEE;
          fired = 1'b1;
          armed = 1'b0;
        end
        gives = 1'b1;
        res.event_detected = fired;
        res.flight_phase = cur_phase;
      end
      default: ;
    endcase
  endtask

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int spread(int jit);
    return int'($urandom_range(0, 2 * jit)) - jit;
  endfunction

  // A word of the given kind with every field random.
  function automatic fpd_pkg::in_word_t any_word(fpd_pkg::op_t op);
    fpd_pkg::in_word_t w;
    w.op = op;
    w.vertical_accel = 16'($urandom);
    w.altitude_sample = 24'($urandom);
    w.forced_phase = 2'($urandom);
    return w;
  endfunction

  // Offer one word after a random gap and hold it until the block takes it.
  task automatic offer_word(input fpd_pkg::in_word_t w, input logic typed,
                            input fpd_pkg::out_word_t want);
    logic gives;
    fpd_pkg::out_word_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_flight(w, gives, res);
    if (gives) phase_reports_due.push_back(typed ? want : res);
    words_sent++;
  endtask

  // Let every outstanding report arrive and the queue behind it drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (phase_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fpd_pkg::CFG_LAUNCH_THR: thr_accel = data[15:0];
      fpd_pkg::CFG_ALT_THR:    thr_alt = data;
      fpd_pkg::CFG_MIN_ACC:    min_seen = data[7:0];
      default: ;
    endcase
  endtask

  // Each block gets its own threshold set: extremes, reset values or random.
  task automatic program_registers(input int blk);
    logic signed [15:0] a;
    logic signed [23:0] h;
    logic [7:0] m;
    case (blk)
      1: begin
        a = 16'sh8000;
        h = 24'sh800000;
        m = 8'd0;
      end
      3: begin
        a = 16'sh7fff;
        h = 24'sh7fffff;
        m = 8'd255;
      end
      4: begin
        a = fpd_pkg::LAUNCH_THR_RST;
        h = fpd_pkg::ALT_THR_RST;
        m = fpd_pkg::MIN_ACC_RST;
      end
      default: begin
        a = 16'(int'($urandom_range(0, 14000)) - 2000);
        h = 24'(int'($urandom_range(0, 6000)) - 3000);
        m = 8'($urandom);
      end
    endcase
    write_register(fpd_pkg::CFG_LAUNCH_THR, {8'($urandom), a});
    write_register(fpd_pkg::CFG_ALT_THR, h);
    write_register(fpd_pkg::CFG_MIN_ACC, {16'($urandom), m});
    write_register(CFG_UNUSED, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // A stretch of words around given accel and altitude levels, with some noise.
  task automatic fly_segment(input int acc_base, input int acc_jit, input int alt_base,
                             input int alt_jit, input int n);
    fpd_pkg::in_word_t w;
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        w = any_word(fpd_pkg::OP_ACCEL);
        w.vertical_accel = 16'(clamp_to(acc_base + spread(acc_jit), -32768, 32767));
      end else if (pick < 70) begin
        w = any_word(fpd_pkg::OP_ALT);
        w.altitude_sample = 24'(clamp_to(alt_base + spread(alt_jit), -8388608, 8388607));
      end else if (pick < 88) begin
        w = any_word(fpd_pkg::OP_EVAL);
      end else if (pick < 94) begin
        w = any_word(fpd_pkg::OP_FORCE);
      end else begin
        w = any_word(fpd_pkg::op_t'(2'($urandom)));
      end
      offer_word(w, 1'b0, '0);
    end
  endtask

  // Pad, boost, coast and descent, levels placed around the current thresholds.
  // Some flights hold acceleration at exactly 25 m/s^2 so landing stays suppressed.
  task automatic fly_once();
    int a_hi, a_lo, h_hi, h_lo;
    logic excl;
    a_hi = int'(thr_accel) + int'($urandom_range(1, 4000));
    a_lo = int'(thr_accel) - int'($urandom_range(200, 4000));
    h_hi = int'(thr_alt) + int'($urandom_range(1, 8000));
    h_lo = int'(thr_alt) - int'($urandom_range(1, 8000));
    excl = ($urandom_range(0, 2) == 0);
    fly_segment(a_lo, 300, h_lo, 400, $urandom_range(15, 40));
    if (excl) begin
      fly_segment(fpd_pkg::LAND_ACCEL_EXCL, 0, h_hi, 300, $urandom_range(140, 180));
      fly_segment(fpd_pkg::LAND_ACCEL_EXCL, 0, h_lo, 300, $urandom_range(60, 100));
    end else begin
      fly_segment(a_hi, 600, h_hi, 300, $urandom_range(100, 160));
      fly_segment(a_lo, 600, h_hi, 300, $urandom_range(20, 60));
      fly_segment(a_lo, 300, h_lo, 300, $urandom_range(80, 140));
    end
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_granted != hold_requests) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each accepted report with the oldest one due.
  always @(posedge clk) begin
    fpd_pkg::out_word_t due;
    if (rst_n && out_valid && !out_stall) begin
      if (phase_reports_due.size() == 0) begin
        $display("%0t: expected no report, got event_detected=%0b flight_phase=%0d",
                 $time, out_word.event_detected, out_word.flight_phase);
        mismatches++;
      end else begin
        due = phase_reports_due.pop_front();
        if (out_word.event_detected !== due.event_detected) begin
          $display("%0t: event_detected expected %0b, got %0b",
                   $time, due.event_detected, out_word.event_detected);
          mismatches++;
        end
        if (out_word.flight_phase !== due.flight_phase) begin
          $display("%0t: flight_phase expected %0d, got %0d",
                   $time, due.flight_phase, out_word.flight_phase);
          mismatches++;
        end
      end
    end
  end

  // Count cycles in which no channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    fpd_pkg::in_word_t w;
    fpd_pkg::out_word_t want;
    step_row_t row;
    int blk_end;
    clear_detector_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words under the reset register values.
    send_idle_pct = 16;
    recv_idle_pct = 81;
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = directed_rows[i];
      w = '0;
      w.op = row.op;
      w.vertical_accel = row.accel;
      w.altitude_sample = row.alt;
      w.forced_phase = row.force_to;
      want.event_detected = row.want_event;
      want.flight_phase = row.want_phase;
      offer_word(w, row.typed, want);
    end

    // Random flights: two blocks in each of the first two idling modes, one in the last.
    for (int blk = 0; blk < N_BLOCKS; blk++) begin
      settle();
      program_registers(blk);
      if (blk == 2) begin
        send_idle_pct = 81;
        recv_idle_pct = 16;
      end else if (blk == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Long receiver hold-off while evaluates keep coming, to back the block up.
        hold_requests++;
        repeat (40) offer_word(any_word(fpd_pkg::OP_EVAL), 1'b0, '0);
      end
      blk_end = words_sent + BLOCK_WORDS;
      while (words_sent < blk_end) fly_once();
    end

    in_valid <= 1'b0;
    while (phase_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> flight_phase_detector.f
+incdir+rtl
rtl/fpd_pkg.sv
rtl/fpd_front.sv
rtl/fpd_ring.sv
rtl/fpd_back.sv
rtl/flight_phase_detector.sv
bench/tb_top.sv
